FILE: design/ymrx_pkg.sv
// Shared constants, types and the CRC function of the YMODEM block receiver.
`timescale 1ns / 1ps

package ymrx_pkg;

    // Block sizes and the counter that walks a block plus its two trailer bytes.
    localparam int SHORT_BLOCK = 128;
    localparam int LONG_BLOCK  = 1024;
    localparam int CNT_W       = $clog2(LONG_BLOCK + 2);
    localparam int IDX_W       = 10;

    // Configuration port shape.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_ABORT_UPPER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ABORT_LOWER = 1'b1;
    localparam logic [7:0] ABORT_UPPER_RST = 8'h41;
    localparam logic [7:0] ABORT_LOWER_RST = 8'h61;

    // Fixed control characters.
    localparam logic [7:0] CH_SOH = 8'h01;
    localparam logic [7:0] CH_STX = 8'h02;
    localparam logic [7:0] CH_EOT = 8'h04;
    localparam logic [7:0] CH_CA  = 8'h18;

    localparam logic [15:0] CRC_POLY     = 16'h1021;
    localparam logic [7:0]  SEQ_INV_MASK = 8'hFF;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_CA,
        PH_SEQ,
        PH_SEQC,
        PH_BODY
    } t_phase;

    typedef enum logic [2:0] {
        ST_GOOD     = 3'd0,
        ST_EOT      = 3'd1,
        ST_CANCEL   = 3'd2,
        ST_ABORT    = 3'd3,
        ST_BADSTART = 3'd4,
        ST_TIMEOUT  = 3'd5,
        ST_SEQERR   = 3'd6,
        ST_CRCERR   = 3'd7
    } t_status;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_STATUS  = 1'b1
    } t_kind;

    typedef enum logic {
        OP_BYTE    = 1'b0,
        OP_TIMEOUT = 1'b1
    } t_op;

    // One byte of CRC-16/XMODEM, MSB first.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

FILE: design/ymrx_if.sv
// Valid/ready channel interfaces for the receiver's input and result words.
`timescale 1ns / 1ps

interface ymrx_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] rx_byte;

    modport source (output valid, output op, output rx_byte, input ready);
    modport sink (input valid, input op, input rx_byte, output ready);
endinterface

interface ymrx_out_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] payload_byte;
    logic [9:0] payload_index;
    logic [7:0] block_number;
    logic       long_block;
    logic [2:0] status;

    modport source (
        output valid, output kind, output payload_byte, output payload_index,
        output block_number, output long_block, output status, input ready
    );
    modport sink (
        input valid, input kind, input payload_byte, input payload_index,
        input block_number, input long_block, input status, output ready
    );
endinterface

FILE: design/ymodem_block_receiver.sv
// YMODEM block receiver: start byte decode, payload streaming and CRC check.
`timescale 1ns / 1ps

// The receiver takes one word per clock cycle while its output register is free,
// either a received byte or a receive timeout, and gives at most one result
// word for it: a payload byte with its index inside the block, or a block
// status. A result appears in the cycle after its input word is taken and waits
// in a single output register; the input stays ready whenever that register is
// empty or is being read, so a sink that never stalls sees a sustained rate of
// one word per cycle. The CRC-16/XMODEM update of one byte is done in the same
// cycle the byte is taken. The abort characters may be rewritten through the
// configuration port while no word is in flight.
module ymodem_block_receiver (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [ymrx_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ymrx_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    ymrx_in_if.sink                           i_in,
    ymrx_out_if.source                        o_out
);
    import ymrx_pkg::*;

    localparam logic [CNT_W-1:0] SIZE_SHORT = CNT_W'(SHORT_BLOCK);
    localparam logic [CNT_W-1:0] SIZE_LONG  = CNT_W'(LONG_BLOCK);

    // Configuration and block state.
    logic [7:0]       r_abort_upper;
    logic [7:0]       r_abort_lower;
    t_phase           r_phase, n_phase;
    logic             r_is_long, n_is_long;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [7:0]       r_seq, n_seq;
    logic [7:0]       r_seqc, n_seqc;
    logic [15:0]      r_crc, n_crc;

    // Output register.
    logic             r_out_valid;
    t_kind            r_kind;
    logic [7:0]       r_pbyte;
    logic [IDX_W-1:0] r_pidx;
    logic [7:0]       r_bnum;
    logic             r_long;
    t_status          r_status;

    // Result of the word being taken.
    logic             res_valid;
    t_kind            res_kind;
    logic [7:0]       res_pbyte;
    logic [IDX_W-1:0] res_pidx;
    logic [7:0]       res_bnum;
    logic             res_long;
    t_status          res_status;

    logic             take;
    logic             out_free;
    logic             is_timeout;
    logic [7:0]       b;
    logic [CNT_W-1:0] blk_size;
    logic [15:0]      crc_next;
    logic [31:0]      cnt_ext;

    assign out_free   = !r_out_valid || o_out.ready;
    assign i_in.ready = out_free;
    assign take       = i_in.valid && out_free;
    assign is_timeout = (t_op'(i_in.op) == OP_TIMEOUT);
    assign b          = i_in.rx_byte;
    assign blk_size   = r_is_long ? SIZE_LONG : SIZE_SHORT;
    assign crc_next   = crc_feed(r_crc, b);
    assign cnt_ext    = 32'(r_cnt);

    // Next state and result for the word at the input.
    always_comb begin
        n_phase    = r_phase;
        n_is_long  = r_is_long;
        n_cnt      = r_cnt;
        n_seq      = r_seq;
        n_seqc     = r_seqc;
        n_crc      = r_crc;
        res_valid  = 1'b0;
        res_kind   = KIND_STATUS;
        res_pbyte  = 8'h00;
        res_pidx   = '0;
        res_bnum   = 8'h00;
        res_long   = 1'b0;
        res_status = ST_GOOD;
        if (take) begin
            case (r_phase)
                PH_IDLE: begin
                    if (is_timeout) begin
                        res_valid  = 1'b1;
                        res_status = ST_TIMEOUT;
                    end else if (b inside {CH_SOH, CH_STX}) begin
                        n_is_long = (b == CH_STX);
                        n_cnt     = '0;
                        n_crc     = 16'h0000;
                        n_phase   = PH_SEQ;
                    end else if (b == CH_EOT) begin
                        res_valid  = 1'b1;
                        res_status = ST_EOT;
                    end else if (b == CH_CA) begin
                        n_phase = PH_CA;
                    end else if (b == r_abort_upper || b == r_abort_lower) begin
                        res_valid  = 1'b1;
                        res_status = ST_ABORT;
                    end else begin
                        res_valid  = 1'b1;
                        res_status = ST_BADSTART;
                    end
                end
                PH_CA: begin
                    n_phase   = PH_IDLE;
                    res_valid = 1'b1;
                    if (is_timeout) begin
                        res_status = ST_ABORT;
                    end else if (b == CH_CA) begin
                        res_status = ST_CANCEL;
                    end else begin
                        res_status = ST_BADSTART;
                    end
                end
                PH_SEQ: begin
                    if (is_timeout) begin
                        n_phase    = PH_IDLE;
                        res_valid  = 1'b1;
                        res_status = ST_TIMEOUT;
                    end else begin
                        n_seq   = b;
                        n_phase = PH_SEQC;
                    end
                end
                PH_SEQC: begin
                    if (is_timeout) begin
                        n_phase    = PH_IDLE;
                        res_valid  = 1'b1;
                        res_status = ST_TIMEOUT;
                    end else begin
                        n_seqc  = b;
                        n_cnt   = '0;
                        n_phase = PH_BODY;
                    end
                end
                PH_BODY: begin
                    if (is_timeout) begin
                        n_phase    = PH_IDLE;
                        res_valid  = 1'b1;
                        res_status = ST_TIMEOUT;
                    end else begin
                        n_crc = crc_next;
                        n_cnt = r_cnt + 1'b1;
                        if (r_cnt < blk_size) begin
                            // Payload byte goes straight out with its index.
                            res_valid = 1'b1;
                            res_kind  = KIND_PAYLOAD;
                            res_pbyte = b;
                            res_pidx  = cnt_ext[IDX_W-1:0];
                        end else if (r_cnt != blk_size) begin
                            // Second trailer byte closes the block.
                            n_phase   = PH_IDLE;
                            res_valid = 1'b1;
                            res_bnum  = r_seq;
                            res_long  = r_is_long;
                            if (r_seq != (r_seqc ^ SEQ_INV_MASK)) begin
                                res_status = ST_SEQERR;
                            end else if (crc_next != 16'h0000) begin
                                res_status = ST_CRCERR;
                            end else begin
                                res_status = ST_GOOD;
                            end
                        end
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_abort_upper <= ABORT_UPPER_RST;
            r_abort_lower <= ABORT_LOWER_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ABORT_UPPER: r_abort_upper <= i_cfg_data;
                CFG_ABORT_LOWER: r_abort_lower <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Block state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_is_long <= 1'b0;
            r_cnt     <= '0;
            r_seq     <= 8'h00;
            r_seqc    <= 8'h00;
            r_crc     <= 16'h0000;
        end else begin
            r_phase   <= n_phase;
            r_is_long <= n_is_long;
            r_cnt     <= n_cnt;
            r_seq     <= n_seq;
            r_seqc    <= n_seqc;
            r_crc     <= n_crc;
        end
    end

    // Output register: valid bit under reset, payload loaded with each result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && res_valid) begin
            r_kind   <= res_kind;
            r_pbyte  <= res_pbyte;
            r_pidx   <= res_pidx;
            r_bnum   <= res_bnum;
            r_long   <= res_long;
            r_status <= res_status;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.kind          = r_kind;
    assign o_out.payload_byte  = r_pbyte;
    assign o_out.payload_index = r_pidx;
    assign o_out.block_number  = r_bnum;
    assign o_out.long_block    = r_long;
    assign o_out.status        = r_status;

`ifndef NO_ASSERTIONS
    // Inside a block the counter never runs past the second trailer byte.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_BODY) |-> (r_cnt <= blk_size + 1'b1))
        else $error("byte counter ran past the end of the block");

    // A payload word only comes from a byte taken inside a block body.
    a_payload_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && r_phase != PH_BODY) |=> !(r_out_valid && r_kind == KIND_PAYLOAD))
        else $error("payload word produced outside a block body");

    // Every status word sends the receiver back to idle.
    a_status_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && res_valid && res_kind == KIND_STATUS) |=> (r_phase == PH_IDLE))
        else $error("receiver did not return to idle after a status word");
`endif

endmodule

FILE: bench/tb_top.sv
// Self-checking testbench for the YMODEM block receiver: stimulus, prediction and checks.
`timescale 1ns / 1ps

module tb_top;
    import ymrx_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 11;
    localparam int MAX_WAIT      = 13;
    localparam int STALL_LIMIT   = 1000;
    localparam int PHASE_WORDS   = 32;
    localparam int SETTLE_CYCLES = 4;

    // One word on the link side and one word on the result side.
    typedef struct packed {
        t_op        op;
        logic [7:0] rx_byte;
    } t_link_event;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] payload_byte;
        logic [9:0] payload_index;
        logic [7:0] block_number;
        logic       long_block;
        t_status    status;
    } t_rx_result;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    ymrx_in_if  link_if ();
    ymrx_out_if res_if ();

    ymodem_block_receiver i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (link_if),
        .o_out      (res_if)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Stimulus words waiting to be sent and results waiting to arrive.
    t_link_event link_events[$];
    t_rx_result  results_due[$];

    // Predicted receiver state and its copy of the abort characters.
    t_phase      rx_phase = PH_IDLE;
    logic        blk_long = 1'b0;
    logic [10:0] blk_count = '0;
    logic [7:0]  blk_seq = '0;
    logic [7:0]  blk_seqc = '0;
    logic [15:0] blk_crc = '0;
    logic [7:0]  abort_hi = ABORT_UPPER_RST;
    logic [7:0]  abort_lo = ABORT_LOWER_RST;

    // Handshake bookkeeping shared by the driver, the sink and the sampler.
    bit in_taken = 1'b0;
    bit word_taken = 1'b0;
    bit word_held = 1'b0;
    bit feed_calm = 1'b0;
    bit sink_calm = 1'b0;
    int feed_gap = 0;
    int sink_wait = 0;
    int idle_cycles = 0;
    int error_count = 0;
    int events_taken = 0;
    int words_checked = 0;
    int blocks_sent = 0;
    int long_blocks = 0;

    task automatic report(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) begin
            report($sformatf("%s is 0x%0h, predicted 0x%0h", name, got, want));
        end
    endtask

    // Bit-serial CRC-16/XMODEM, most significant bit first.
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    // Every status word sends the receiver back to idle.
    function automatic bit status_word(input t_status st, input logic [7:0] num,
                                       input logic lng, output t_rx_result res);
        res              = '0;
        res.kind         = KIND_STATUS;
        res.block_number = num;
        res.long_block   = lng;
        res.status       = st;
        rx_phase         = PH_IDLE;
        return 1'b1;
    endfunction

    // Advances the predicted state by one link word; returns 1 when a result is due.
    function automatic bit receiver_step(input t_link_event ev, output t_rx_result res);
        int         limit;
        logic [7:0] b;
        res   = '0;
        b     = ev.rx_byte;
        limit = blk_long ? LONG_BLOCK : SHORT_BLOCK;
        case (rx_phase)
            PH_IDLE: begin
                if (ev.op == OP_TIMEOUT) return status_word(ST_TIMEOUT, 8'h00, 1'b0, res);
                if (b == CH_SOH || b == CH_STX) begin
                    blk_long  = (b == CH_STX);
                    blk_count = '0;
                    blk_crc   = '0;
                    rx_phase  = PH_SEQ;
                    return 1'b0;
                end
                if (b == CH_EOT) return status_word(ST_EOT, 8'h00, 1'b0, res);
                if (b == CH_CA) begin
                    rx_phase = PH_CA;
                    return 1'b0;
                end
                if (b == abort_hi || b == abort_lo) begin
                    return status_word(ST_ABORT, 8'h00, 1'b0, res);
                end
                return status_word(ST_BADSTART, 8'h00, 1'b0, res);
            end
            PH_CA: begin
                if (ev.op == OP_TIMEOUT) return status_word(ST_ABORT, 8'h00, 1'b0, res);
                if (b == CH_CA) return status_word(ST_CANCEL, 8'h00, 1'b0, res);
                return status_word(ST_BADSTART, 8'h00, 1'b0, res);
            end
            PH_SEQ: begin
                if (ev.op == OP_TIMEOUT) return status_word(ST_TIMEOUT, 8'h00, 1'b0, res);
                blk_seq  = b;
                rx_phase = PH_SEQC;
                return 1'b0;
            end
            PH_SEQC: begin
                if (ev.op == OP_TIMEOUT) return status_word(ST_TIMEOUT, 8'h00, 1'b0, res);
                blk_seqc  = b;
                blk_count = '0;
                rx_phase  = PH_BODY;
                return 1'b0;
            end
            PH_BODY: begin
                if (ev.op == OP_TIMEOUT) return status_word(ST_TIMEOUT, 8'h00, 1'b0, res);
                blk_crc = crc_step(blk_crc, b);
                if (blk_count < limit) begin
                    res.kind          = KIND_PAYLOAD;
                    res.payload_byte  = b;
                    res.payload_index = blk_count[9:0];
                    blk_count++;
                    return 1'b1;
                end
                blk_count++;
                if (blk_count < limit + 2) return 1'b0;
                if (blk_seq != (blk_seqc ^ SEQ_INV_MASK)) begin
                    return status_word(ST_SEQERR, blk_seq, blk_long, res);
                end
                if (blk_crc != 16'h0000) return status_word(ST_CRCERR, blk_seq, blk_long, res);
                return status_word(ST_GOOD, blk_seq, blk_long, res);
            end
            default: rx_phase = PH_IDLE;
        endcase
        return 1'b0;
    endfunction

    // Wait drawn per word; now and then a stretch with no waiting at all.
    function automatic int draw_wait(inout bit calm);
        if ($urandom_range(0, 39) == 0) calm = !calm;
        return calm ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    task automatic push_byte(input logic [7:0] b);
        t_link_event ev;
        ev.op      = OP_BYTE;
        ev.rx_byte = b;
        link_events.push_back(ev);
    endtask

    task automatic push_timeout();
        t_link_event ev;
        ev.op      = OP_TIMEOUT;
        ev.rx_byte = 8'($urandom_range(0, 255));
        link_events.push_back(ev);
    endtask

    // A whole block with a valid trailer unless told otherwise; a cut position
    // replaces the rest of the block, counted from the sequence byte, by a timeout.
    task automatic push_block(input bit lng, input logic [7:0] seq, input logic [7:0] seqc,
                              input bit bad_crc, input int cut_at);
        int          n;
        logic [15:0] crc;
        logic [7:0]  b;
        n   = lng ? LONG_BLOCK : SHORT_BLOCK;
        crc = '0;
        blocks_sent++;
        if (lng) long_blocks++;
        push_byte(lng ? CH_STX : CH_SOH);
        for (int k = 0; k < n + 4; k++) begin
            if (k == cut_at) begin
                push_timeout();
                return;
            end
            if (k == 0) begin
                b = seq;
            end else if (k == 1) begin
                b = seqc;
            end else if (k < n + 2) begin
                b   = 8'($urandom_range(0, 255));
                crc = crc_step(crc, b);
            end else if (k == n + 2) begin
                b = crc[15:8];
            end else begin
                b = bad_crc ? crc[7:0] ^ 8'($urandom_range(1, 255)) : crc[7:0];
            end
            push_byte(b);
        end
    endtask

    // Mostly well-formed blocks with random content, the rest control bytes and noise.
    task automatic push_random_unit();
        int         sel;
        int         flaw;
        logic [7:0] seq;
        sel = $urandom_range(0, 99);
        seq = 8'($urandom_range(0, 255));
        if (sel < 60) begin
            flaw = $urandom_range(0, 9);
            push_block(1'b0, seq,
                       (flaw == 0) ? ~seq ^ 8'($urandom_range(1, 255)) : ~seq,
                       flaw == 1,
                       (flaw == 2) ? int'($urandom_range(0, SHORT_BLOCK + 3)) : -1);
        end else if (sel < 68) begin
            push_byte(CH_EOT);
        end else if (sel < 74) begin
            push_byte(CH_CA);
            push_byte(CH_CA);
        end else if (sel < 78) begin
            push_byte(CH_CA);
            push_byte(8'($urandom_range(0, 255)));
        end else if (sel < 82) begin
            push_byte(CH_CA);
            push_timeout();
        end else if (sel < 88) begin
            push_byte($urandom_range(0, 1) ? abort_hi : abort_lo);
        end else if (sel < 94) begin
            push_byte(8'($urandom_range(0, 255)));
        end else begin
            push_timeout();
        end
    endtask

    task automatic push_random_part();
        int base;
        base = link_events.size();
        while (link_events.size() < base + PHASE_WORDS) push_random_unit();
    endtask

    // The sender holds off until every predicted result has come back.
    task automatic wait_drained();
        while (link_events.size() != 0 || word_held || results_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_abort_chars(input logic [7:0] hi, input logic [7:0] lo);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_ABORT_UPPER;
        i_cfg_data <= hi;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_ABORT_LOWER;
        i_cfg_data <= lo;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        abort_hi = hi;
        abort_lo = lo;
    endtask

    // Link driver: presents the next pending word after its drawn gap.
    always @(negedge i_clk) begin : drive_link
        t_link_event next_ev;
        if (!i_rst_n) begin
            link_if.valid <= 1'b0;
            word_held = 1'b0;
            feed_gap  = 0;
        end else begin
            if (in_taken) begin
                in_taken  = 1'b0;
                word_held = 1'b0;
                feed_gap  = draw_wait(feed_calm);
            end
            if (!word_held) begin
                if (feed_gap > 0) begin
                    feed_gap--;
                end else if (link_events.size() != 0) begin
                    next_ev = link_events.pop_front();
                    link_if.op      <= next_ev.op;
                    link_if.rx_byte <= next_ev.rx_byte;
                    word_held = 1'b1;
                end
            end
            link_if.valid <= word_held;
        end
    end

    // Result sink: after each taken word, holds ready low for a drawn stall.
    always @(negedge i_clk) begin : drive_sink
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            sink_wait = 0;
        end else begin
            if (word_taken) begin
                word_taken = 1'b0;
                sink_wait  = draw_wait(sink_calm);
            end
            if (sink_wait > 0) begin
                sink_wait--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // Sampler: predicts on every taken link word, checks every taken result word.
    always @(posedge i_clk) begin : sample_ports
        t_link_event ev;
        t_rx_result  want;
        t_rx_result  got;
        t_rx_result  due;
        bit          moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (link_if.valid && link_if.ready) begin
                ev.op      = t_op'(link_if.op);
                ev.rx_byte = link_if.rx_byte;
                if (receiver_step(ev, want)) results_due.push_back(want);
                in_taken = 1'b1;
                events_taken++;
                moved = 1'b1;
            end
            if (res_if.valid && res_if.ready) begin
                got.kind          = t_kind'(res_if.kind);
                got.payload_byte  = res_if.payload_byte;
                got.payload_index = res_if.payload_index;
                got.block_number  = res_if.block_number;
                got.long_block    = res_if.long_block;
                got.status        = t_status'(res_if.status);
                if (results_due.size() == 0) begin
                    report($sformatf("result word 0x%0h with none predicted", got));
                end else begin
                    due = results_due.pop_front();
                    check_field("kind", 16'(got.kind), 16'(due.kind));
                    check_field("payload_byte", 16'(got.payload_byte),
                                16'(due.payload_byte));
                    check_field("payload_index", 16'(got.payload_index),
                                16'(due.payload_index));
                    check_field("block_number", 16'(got.block_number),
                                16'(due.block_number));
                    check_field("long_block", 16'(got.long_block), 16'(due.long_block));
                    check_field("status", 16'(got.status), 16'(due.status));
                end
                word_taken = 1'b1;
                words_checked++;
                moved = 1'b1;
            end
            // Watchdog on cycles in which no word moves on either side.
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t ns: no word moved for %0d cycles", $time, STALL_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Sequence of phases, each under its own pair of abort characters.
    initial begin : run_phases
        int guard;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = '0;
        i_cfg_data      = '0;
        link_if.valid   = 1'b0;
        link_if.op      = 1'b0;
        link_if.rx_byte = '0;
        res_if.ready    = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed start codes, control pairs and early timeouts, default abort chars.
        push_timeout();
        push_byte(CH_EOT);
        push_byte(CH_CA);
        push_byte(CH_CA);
        push_byte(CH_CA);
        push_byte(8'h00);
        push_byte(CH_CA);
        push_timeout();
        push_byte(ABORT_UPPER_RST);
        push_byte(ABORT_LOWER_RST);
        push_byte(8'hFF);
        push_byte(8'h00);
        push_byte(CH_SOH);
        push_timeout();
        push_byte(CH_STX);
        push_byte(8'h00);
        push_timeout();
        push_byte(CH_SOH);
        push_byte(8'h01);
        push_byte(8'hFE);
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'h55);
        push_timeout();
        push_random_part();
        wait_drained();

        // Extreme abort characters and one full long block.
        write_abort_chars(8'h00, 8'hFF);
        begin : long_phase
            logic [7:0] seq;
            seq = 8'($urandom_range(0, 255));
            push_block(1'b1, seq, ~seq, 1'b0, -1);
        end
        push_random_part();
        wait_drained();

        // Abort characters that collide with start codes: the start codes win.
        write_abort_chars(CH_SOH, CH_CA);
        push_byte(CH_CA);
        push_byte(CH_CA);
        push_block(1'b0, 8'h00, 8'hFF, 1'b0, -1);
        push_random_part();
        wait_drained();

        // Random abort characters.
        write_abort_chars(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        push_random_part();

        // Let the last results come back, then watch a few more cycles for strays.
        while (link_events.size() != 0 || word_held) @(posedge i_clk);
        for (guard = 0; guard < STALL_LIMIT / 2 && results_due.size() != 0; guard++) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES * 2) @(posedge i_clk);
        if (results_due.size() != 0) begin
            report($sformatf("%0d predicted results never arrived", results_due.size()));
        end

        $display("Run covered %0d link words and %0d result words, %0d blocks (%0d long).",
                 events_taken, words_checked, blocks_sent, long_blocks);
        $display("Abort characters ran at reset, extreme, start-code and random values.");
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
